### design/hmvn_pkg.sv
// Shared types, constants and helpers for the heightmap vertex normal block.
`timescale 1ns / 1ps
`default_nettype none
package hmvn_pkg;

	// Grid and number format
	localparam int MAX_GRID    = 128;
	localparam int POS_W       = $clog2(MAX_GRID);
	localparam int FRAC_BITS   = 14;
	localparam int COMP_W      = 16;
	localparam int RAW_W       = 18;
	localparam int MAG_W       = RAW_W - 1;
	localparam int ACC_W       = 2 * MAG_W + 2;
	localparam int PRE_SHIFT   = 20;
	localparam int SQ_W        = ACC_W + PRE_SHIFT;
	localparam int ROOT_W      = SQ_W / 2;
	localparam int ROOT_STEPS  = SQ_W / 2;
	localparam int QUO_W       = 17;
	localparam int NUM_SHIFT   = FRAC_BITS + 10;
	localparam int NUM_W       = MAG_W + NUM_SHIFT;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int OUT_W       = 64;

	localparam logic [COMP_W-1:0] ONE_VAL = COMP_W'(1 << FRAC_BITS);

	// Configuration register indexes
	localparam logic [1:0] REG_GRID_COLUMNS = 2'd0;
	localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
	localparam logic [1:0] REG_STEP         = 2'd2;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [RAW_W-1:0]  raw_t;

	typedef struct packed {
		comp_t z;
		comp_t y;
		comp_t x;
	} unit_vec_t;

	typedef struct packed {
		raw_t z;
		raw_t y;
		raw_t x;
	} raw_vec_t;

	// Active grid settings, sizes already clamped
	typedef struct packed {
		logic [7:0]  cols;
		logic [7:0]  rows;
		logic [15:0] step;
	} grid_cfg_t;

	// One cell handed from the front to the back
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [7:0]       h00;
		logic [7:0]       h01;
		logic [7:0]       h10;
		logic [7:0]       h11;
		logic             last_col;
		logic             last_row;
	} cell_t;

	function automatic logic [7:0] clamp_size(input logic [7:0] v);
		logic [7:0] r;
		if (v < 8'd2) r = 8'd2;
		else if (v > 8'(MAX_GRID)) r = 8'(MAX_GRID);
		else r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

### design/heightmap_vertex_normals.sv
// Top level of the heightmap vertex normal block.
//
// Channel   Dir  Signals                        Contents (low bit up)
// config    in   cfg_we, cfg_index, cfg_data    grid_columns, grid_rows, step_over_height_unit
// samples   in   s_tvalid/s_tready/s_tdata/s_tuser  tdata: height; tuser: frame_start
// normals   out  m_tvalid/m_tready/m_tdata/m_tlast  tdata: x, y, z, row, column
//
// The front takes each sample through an accept and a line-read state into a 4-cell queue,
// stalling only while it must push and the queue is full. The back runs one shared
// normalizer for both faces of a cell, then a sum, normalize and output step for each of
// the one to four vertices the cell completes, plus a pop and a finish step.
// Samples in row 0 or column 0 pass through the front only and are never queued.
// Reset clears position, neighbor faces and queue; line stores need no clear.
// A stalled result output stops the back only; the front keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_vertex_normals (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // height[7:0]
	input  wire logic        s_tuser,  // frame_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// normal_x[15:0], normal_y[31:16], normal_z[47:32], vertex_row[54:48],
	// vertex_column[61:55], zero[63:62]
	output logic [63:0]      m_tdata,
	output logic             m_tlast
);

	logic [7:0]          cols_q, rows_q;
	logic [15:0]         step_q;
	hmvn_pkg::grid_cfg_t cfg;
	hmvn_pkg::cell_t     push_cell, pop_cell;
	logic                q_push, q_full, q_pop, q_empty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 8'd128;
			rows_q <= 8'd128;
			step_q <= 16'd653;
		end else if (cfg_we) begin
			case (cfg_index)
				hmvn_pkg::REG_GRID_COLUMNS: cols_q <= cfg_data[7:0];
				hmvn_pkg::REG_GRID_ROWS:    rows_q <= cfg_data[7:0];
				hmvn_pkg::REG_STEP:         step_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.cols = hmvn_pkg::clamp_size(cols_q);
	assign cfg.rows = hmvn_pkg::clamp_size(rows_q);
	assign cfg.step = step_q;

	hmvn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.height      (s_tdata),
		.frame_start (s_tuser),
		.q_push      (q_push),
		.q_data      (push_cell),
		.q_full      (q_full)
	);

	hmvn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cell),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_cell),
		.empty     (q_empty)
	);

	hmvn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_data   (pop_cell),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

### design/hmvn_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module hmvn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

### design/hmvn_norm.sv
// Iterative unit-length normalizer: squares, bitwise square root, three dividers.
`timescale 1ns / 1ps
`default_nettype none
module hmvn_norm (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire hmvn_pkg::raw_vec_t  vec,
	output logic                     done,
	output hmvn_pkg::unit_vec_t      res
);

	typedef enum logic [5:0] {
		N_IDLE = 6'b000001,
		N_SQ   = 6'b000010,
		N_ROOT = 6'b000100,
		N_PREP = 6'b001000,
		N_DIV  = 6'b010000,
		N_DONE = 6'b100000
	} norm_state_t;

	norm_state_t                      state_q;
	logic [4:0]                       cnt_q;
	logic [hmvn_pkg::MAG_W-1:0]       mag_q [3];
	logic                             neg_q [3];
	logic [hmvn_pkg::ACC_W-1:0]       acc_q;
	logic [hmvn_pkg::SQ_W-1:0]        v_q, r_q, bit_q;
	logic [hmvn_pkg::ROOT_W-1:0]      rem_q [3];
	logic [hmvn_pkg::QUO_W-1:0]       nlo_q [3];
	logic [hmvn_pkg::QUO_W-1:0]       quo_q [3];
	logic [hmvn_pkg::COMP_W-1:0]      res_q [3];

	logic [hmvn_pkg::MAG_W-1:0]       sq_sel;
	logic [hmvn_pkg::ACC_W-1:0]       acc_nx;
	logic [hmvn_pkg::SQ_W-1:0]        root_t;
	logic [hmvn_pkg::ROOT_W-1:0]      len;
	logic [hmvn_pkg::QUO_W-1:0]       quo_nx [3];
	logic [hmvn_pkg::ROOT_W-1:0]      rem_nx [3];
	logic [hmvn_pkg::COMP_W-1:0]      cap_nx [3];
	hmvn_pkg::raw_t                   src [3];

	assign src[0] = vec.x;
	assign src[1] = vec.y;
	assign src[2] = vec.z;
	assign len    = r_q[hmvn_pkg::ROOT_W-1:0];

	// Sum of squares, one component a cycle
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_sel = mag_q[0];
			2'd1:    sq_sel = mag_q[1];
			default: sq_sel = mag_q[2];
		endcase
		acc_nx = acc_q + hmvn_pkg::ACC_W'(sq_sel * sq_sel);
		root_t = r_q + bit_q;
	end

	// One restoring divide step per component, then cap and sign
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [hmvn_pkg::ROOT_W:0] t;
			logic [hmvn_pkg::QUO_W-1:0] m;
			t = {rem_q[k], nlo_q[k][hmvn_pkg::QUO_W-1]};
			if (t >= {1'b0, len}) begin
				rem_nx[k] = hmvn_pkg::ROOT_W'(t - {1'b0, len});
				quo_nx[k] = {quo_q[k][hmvn_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_nx[k] = t[hmvn_pkg::ROOT_W-1:0];
				quo_nx[k] = {quo_q[k][hmvn_pkg::QUO_W-2:0], 1'b0};
			end
			m = (quo_nx[k] > hmvn_pkg::QUO_W'(hmvn_pkg::ONE_VAL)) ?
				hmvn_pkg::QUO_W'(hmvn_pkg::ONE_VAL) : quo_nx[k];
			cap_nx[k] = neg_q[k] ? hmvn_pkg::COMP_W'(-m) : hmvn_pkg::COMP_W'(m);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				N_IDLE: begin
					if (start) begin
						state_q <= N_SQ;
						cnt_q   <= '0;
					end
				end
				N_SQ: begin
					if (cnt_q == 5'd2) begin
						cnt_q   <= '0;
						state_q <= (acc_nx == '0) ? N_DONE : N_ROOT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				N_ROOT: begin
					if (cnt_q == 5'(hmvn_pkg::ROOT_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= N_PREP;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				N_PREP: begin
					cnt_q   <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					if (cnt_q == 5'(hmvn_pkg::QUO_W - 1)) begin
						state_q <= N_DONE;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					acc_q <= '0;
					for (int k = 0; k < 3; k++) begin
						logic [hmvn_pkg::RAW_W-1:0] a;
						a = src[k][hmvn_pkg::RAW_W-1] ? -src[k] : src[k];
						neg_q[k] <= src[k][hmvn_pkg::RAW_W-1];
						mag_q[k] <= a[hmvn_pkg::MAG_W-1:0];
					end
				end
			end
			N_SQ: begin
				acc_q <= acc_nx;
				if (cnt_q == 5'd2) begin
					v_q   <= {acc_nx, hmvn_pkg::PRE_SHIFT'(0)};
					r_q   <= '0;
					bit_q <= hmvn_pkg::SQ_W'(1) << (hmvn_pkg::SQ_W - 2);
					if (acc_nx == '0) begin
						res_q[0] <= '0;
						res_q[1] <= '0;
						res_q[2] <= hmvn_pkg::ONE_VAL;
					end
				end
			end
			N_ROOT: begin
				if (v_q >= root_t) begin
					v_q <= v_q - root_t;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_PREP: begin
				for (int k = 0; k < 3; k++) begin
					logic [hmvn_pkg::NUM_W-1:0] num;
					num = {mag_q[k], hmvn_pkg::NUM_SHIFT'(0)}
						+ hmvn_pkg::NUM_W'(len >> 1);
					rem_q[k] <= hmvn_pkg::ROOT_W'(num[hmvn_pkg::NUM_W-1:hmvn_pkg::QUO_W]);
					nlo_q[k] <= num[hmvn_pkg::QUO_W-1:0];
					quo_q[k] <= '0;
				end
			end
			N_DIV: begin
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= rem_nx[k];
					nlo_q[k] <= nlo_q[k] << 1;
					quo_q[k] <= quo_nx[k];
					if (cnt_q == 5'(hmvn_pkg::QUO_W - 1)) begin
						res_q[k] <= cap_nx[k];
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done  = (state_q == N_DONE);
	assign res.x = res_q[0];
	assign res.y = res_q[1];
	assign res.z = res_q[2];

endmodule
`default_nettype wire

### design/hmvn_front.sv
// Front end: accepts samples, tracks grid position, keeps the height line.
`timescale 1ns / 1ps
`default_nettype none
module hmvn_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hmvn_pkg::grid_cfg_t cfg,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          height,
	input  wire logic                frame_start,
	output logic                     q_push,
	output hmvn_pkg::cell_t          q_data,
	input  wire logic                q_full
);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_READ = 2'b10
	} front_state_t;

	front_state_t                state_q;
	logic [hmvn_pkg::POS_W-1:0]  row_q, col_q;
	logic [hmvn_pkg::POS_W-1:0]  smp_row_q, smp_col_q;
	logic [7:0]                  smp_h_q;
	logic [7:0]                  left_q, upper_left_q;
	logic [7:0]                  c_w, r_w, c_inc, r_inc;
	logic [hmvn_pkg::POS_W-1:0]  rd_addr;
	logic [7:0]                  h01;
	logic                        need_push, leave;

	// Resolve the position of the incoming sample
	always_comb begin
		if (frame_start) begin
			c_w = '0;
			r_w = '0;
		end else begin
			c_w = {1'b0, col_q};
			r_w = {1'b0, row_q};
			if (c_w >= cfg.cols) begin
				c_w = '0;
				r_w = r_w + 8'd1;
			end
			if (r_w >= cfg.rows) begin
				r_w = '0;
			end
		end
		c_inc = c_w + 8'd1;
		r_inc = r_w + 8'd1;
	end

	assign rd_addr   = (state_q == F_IDLE) ? c_w[hmvn_pkg::POS_W-1:0] : smp_col_q;
	assign need_push = (smp_row_q != '0) && (smp_col_q != '0);
	assign leave     = (state_q == F_READ) && (!need_push || !q_full);
	assign s_tready  = (state_q == F_IDLE);
	assign q_push    = leave && need_push;

	// Cell for the back end
	always_comb begin
		q_data.row      = smp_row_q;
		q_data.col      = smp_col_q;
		q_data.h00      = upper_left_q;
		q_data.h01      = h01;
		q_data.h10      = left_q;
		q_data.h11      = smp_h_q;
		q_data.last_col = ({1'b0, smp_col_q} == cfg.cols - 8'd1);
		q_data.last_row = ({1'b0, smp_row_q} == cfg.rows - 8'd1);
	end

	hmvn_ram #(.WIDTH(8), .DEPTH(hmvn_pkg::MAX_GRID)) u_height_line (
		.clk     (clk),
		.we      (leave),
		.wr_addr (smp_col_q),
		.wr_data (smp_h_q),
		.rd_addr (rd_addr),
		.rd_data (h01)
	);

	// Control: accept, then hand over once the line read is back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			row_q        <= '0;
			col_q        <= '0;
			left_q       <= '0;
			upper_left_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						state_q <= F_READ;
						if (c_inc >= cfg.cols) begin
							col_q <= '0;
							row_q <= (r_inc >= cfg.rows) ? '0 : r_inc[hmvn_pkg::POS_W-1:0];
						end else begin
							col_q <= c_inc[hmvn_pkg::POS_W-1:0];
							row_q <= r_w[hmvn_pkg::POS_W-1:0];
						end
					end
				end
				F_READ: begin
					if (leave) begin
						state_q      <= F_IDLE;
						upper_left_q <= h01;
						left_q       <= smp_h_q;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Sample capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			smp_row_q <= r_w[hmvn_pkg::POS_W-1:0];
			smp_col_q <= c_w[hmvn_pkg::POS_W-1:0];
			smp_h_q   <= height;
		end
	end

endmodule
`default_nettype wire

### design/hmvn_queue.sv
// Short queue of cells between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module hmvn_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire hmvn_pkg::cell_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output hmvn_pkg::cell_t      pop_data,
	output logic                 empty
);

	hmvn_pkg::cell_t             entry_q [hmvn_pkg::QUEUE_DEPTH];
	logic [hmvn_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [hmvn_pkg::QPTR_W:0]   count_q;

	assign full     = (count_q == (hmvn_pkg::QPTR_W+1)'(hmvn_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && !empty) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push && !full) entry_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

### design/hmvn_back.sv
// Back end: face normals, vertex sums and result output.
`timescale 1ns / 1ps
`default_nettype none
module hmvn_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hmvn_pkg::grid_cfg_t cfg,
	input  wire logic                q_empty,
	output logic                     q_pop,
	input  wire hmvn_pkg::cell_t     q_data,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [hmvn_pkg::OUT_W-1:0] m_tdata,
	output logic                     m_tlast
);

	typedef enum logic [8:0] {
		B_IDLE    = 9'b000000001,
		B_LO_GO   = 9'b000000010,
		B_LO_WAIT = 9'b000000100,
		B_UP_GO   = 9'b000001000,
		B_UP_WAIT = 9'b000010000,
		B_SUM     = 9'b000100000,
		B_V_GO    = 9'b001000000,
		B_V_WAIT  = 9'b010000000,
		B_EMIT    = 9'b100000000
	} back_state_t;

	back_state_t                 state_q;
	logic                        fin_q;
	hmvn_pkg::cell_t             ent_q;
	hmvn_pkg::unit_vec_t         lo_q, up_q;
	hmvn_pkg::unit_vec_t         left_lo_q, left_up_q, diag_lo_q, diag_up_q;
	hmvn_pkg::raw_vec_t          sum_q;
	logic [1:0]                  vtx_q;
	logic [hmvn_pkg::POS_W-1:0]  vi_q, vj_q;
	logic                        vlast_q;
	logic                        m_tvalid_q, m_tlast_q;
	logic [hmvn_pkg::OUT_W-1:0]  m_tdata_q;

	logic [hmvn_pkg::POS_W-1:0]  face_addr;
	hmvn_pkg::unit_vec_t         old_lo, old_up;
	hmvn_pkg::raw_vec_t          raw_lo, raw_up, norm_vec;
	hmvn_pkg::raw_vec_t          sum_w;
	hmvn_pkg::unit_vec_t         norm_res;
	logic                        norm_start, norm_done;
	logic [hmvn_pkg::POS_W-1:0]  vi_w, vj_w;
	logic                        next_ok;
	logic [1:0]                  next_vtx;
	logic                        out_free;

	function automatic hmvn_pkg::raw_t scaled_diff(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] d;
		d = {1'b0, a} - {1'b0, b};
		return {d[8], d, 8'd0};
	endfunction

	function automatic hmvn_pkg::raw_t ext(input hmvn_pkg::comp_t v);
		return {{(hmvn_pkg::RAW_W-hmvn_pkg::COMP_W){v[hmvn_pkg::COMP_W-1]}}, v};
	endfunction

	// Raw face vectors of the current cell
	always_comb begin
		raw_lo.x = scaled_diff(ent_q.h10, ent_q.h11);
		raw_lo.y = scaled_diff(ent_q.h00, ent_q.h10);
		raw_lo.z = {2'b00, cfg.step};
		raw_up.x = scaled_diff(ent_q.h00, ent_q.h01);
		raw_up.y = scaled_diff(ent_q.h01, ent_q.h11);
		raw_up.z = {2'b00, cfg.step};
	end

	assign face_addr = ent_q.col - 1'b1;

	hmvn_ram #(.WIDTH(2 * $bits(hmvn_pkg::unit_vec_t)), .DEPTH(hmvn_pkg::MAX_GRID)) u_face_line (
		.clk     (clk),
		.we      (fin_q),
		.wr_addr (face_addr),
		.wr_data ({lo_q, up_q}),
		.rd_addr (face_addr),
		.rd_data ({old_lo, old_up})
	);

	// Faces around the selected vertex and its scaled sum
	always_comb begin
		hmvn_pkg::unit_vec_t a0, a1, b1, d0, d1, e0;
		logic here, above, left, right;
		a0 = lo_q;
		a1 = up_q;
		b1 = up_q;
		d0 = lo_q;
		d1 = up_q;
		e0 = lo_q;
		vi_w = ent_q.row;
		vj_w = ent_q.col;
		case (vtx_q)
			2'd0: begin
				b1 = left_up_q;
				d0 = diag_lo_q;
				d1 = diag_up_q;
				e0 = old_lo;
				vi_w = ent_q.row - 1'b1;
				vj_w = ent_q.col - 1'b1;
			end
			2'd1: begin
				d0 = old_lo;
				d1 = old_up;
				e0 = old_lo;
				vi_w = ent_q.row - 1'b1;
			end
			2'd2: begin
				d0 = left_lo_q;
				d1 = left_up_q;
				vj_w = ent_q.col - 1'b1;
			end
			default: begin
			end
		endcase
		here  = ({1'b0, vi_w} + 8'd2) <= cfg.rows;
		right = ({1'b0, vj_w} + 8'd2) <= cfg.cols;
		above = (vi_w != '0);
		left  = (vj_w != '0);
		sum_w.x = ((here && right) ? ext(a0.x) + ext(a1.x) : '0)
			+ ((here && left) ? ext(b1.x) : '0)
			+ ((above && left) ? ext(d0.x) + ext(d1.x) : '0)
			+ ((above && right) ? ext(e0.x) : '0);
		sum_w.y = ((here && right) ? ext(a0.y) + ext(a1.y) : '0)
			+ ((here && left) ? ext(b1.y) : '0)
			+ ((above && left) ? ext(d0.y) + ext(d1.y) : '0)
			+ ((above && right) ? ext(e0.y) : '0);
		sum_w.z = ((here && right) ? ext(a0.z) + ext(a1.z) : '0)
			+ ((here && left) ? ext(b1.z) : '0)
			+ ((above && left) ? ext(d0.z) + ext(d1.z) : '0)
			+ ((above && right) ? ext(e0.z) : '0);
	end

	// Next vertex this cell completes
	always_comb begin
		next_ok  = 1'b0;
		next_vtx = 2'd0;
		case (vtx_q)
			2'd0: begin
				if (ent_q.last_col) begin
					next_ok  = 1'b1;
					next_vtx = 2'd1;
				end else if (ent_q.last_row) begin
					next_ok  = 1'b1;
					next_vtx = 2'd2;
				end
			end
			2'd1: begin
				if (ent_q.last_row) begin
					next_ok  = 1'b1;
					next_vtx = 2'd2;
				end
			end
			2'd2: begin
				if (ent_q.last_col) begin
					next_ok  = 1'b1;
					next_vtx = 2'd3;
				end
			end
			default: begin
			end
		endcase
	end

	// Normalizer operand select
	always_comb begin
		case (state_q)
			B_LO_GO: norm_vec = raw_lo;
			B_UP_GO: norm_vec = raw_up;
			default: norm_vec = sum_q;
		endcase
	end

	assign norm_start = (state_q == B_LO_GO) || (state_q == B_UP_GO) || (state_q == B_V_GO);
	assign q_pop      = (state_q == B_IDLE) && !fin_q && !q_empty;
	assign out_free   = !m_tvalid_q || m_tready;

	hmvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vec    (norm_vec),
		.done   (norm_done),
		.res    (norm_res)
	);

	// Sequencer and neighbor faces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			fin_q     <= 1'b0;
			vtx_q     <= '0;
			left_lo_q <= '0;
			left_up_q <= '0;
			diag_lo_q <= '0;
			diag_up_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (fin_q) begin
				diag_lo_q <= old_lo;
				diag_up_q <= old_up;
				left_lo_q <= lo_q;
				left_up_q <= up_q;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop) state_q <= B_LO_GO;
				end
				B_LO_GO: state_q <= B_LO_WAIT;
				B_LO_WAIT: begin
					if (norm_done) state_q <= B_UP_GO;
				end
				B_UP_GO: state_q <= B_UP_WAIT;
				B_UP_WAIT: begin
					if (norm_done) begin
						state_q <= B_SUM;
						vtx_q   <= 2'd0;
					end
				end
				B_SUM: state_q <= B_V_GO;
				B_V_GO: state_q <= B_V_WAIT;
				B_V_WAIT: begin
					if (norm_done) state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (out_free) begin
						if (next_ok) begin
							vtx_q   <= next_vtx;
							state_q <= B_SUM;
						end else begin
							fin_q   <= 1'b1;
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		if (q_pop) ent_q <= q_data;
		if (state_q == B_LO_WAIT && norm_done) lo_q <= norm_res;
		if (state_q == B_UP_WAIT && norm_done) up_q <= norm_res;
		if (state_q == B_SUM) begin
			sum_q   <= sum_w;
			vi_q    <= vi_w;
			vj_q    <= vj_w;
			vlast_q <= !next_ok;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == B_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_EMIT && out_free) begin
			m_tdata_q <= {2'b00, vj_q, vi_q, norm_res.z, norm_res.y, norm_res.x};
			m_tlast_q <= vlast_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

### design/hmvn_checker.sv
// Port-level checks for the heightmap vertex normal block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hmvn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_we,
	input wire logic [1:0]  cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic        m_tlast
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// Keep every component within unit range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384)
			&& ($signed(m_tdata[15:0]) >= -16'sd16384)
			&& ($signed(m_tdata[31:16]) <= 16'sd16384)
			&& ($signed(m_tdata[31:16]) >= -16'sd16384)
			&& ($signed(m_tdata[47:32]) <= 16'sd16384)
			&& ($signed(m_tdata[47:32]) >= -16'sd16384))
		else $error("normal component out of range");

	// Never emit a zero vector
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47:0] != 48'd0))
		else $error("zero normal emitted");

	// Keep padding bits clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:62] == 2'b00))
		else $error("padding bits set");

endmodule

bind heightmap_vertex_normals hmvn_checker u_hmvn_checker (.*);
`default_nettype wire
